### sv/spike_buffer_to_joint_pulse_drive_top_assert.svh
// assertion macros for the spike buffer pulse drive
`ifndef SPIKE_BUFFER_TO_JOINT_PULSE_DRIVE_TOP_ASSERT_SVH
`define SPIKE_BUFFER_TO_JOINT_PULSE_DRIVE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SBJPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SBJPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sbjpd_pkg.sv
`timescale 1ns / 1ps

package sbjpd_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;

    localparam int STAMP_W    = 63;
    localparam int LAYER_W    = 3;
    localparam int MODE_W     = 3;
    localparam int ERR_W      = 2;
    localparam int PULSE_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int DRAIN_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ENTRY_W    = STAMP_W + LAYER_W;

    localparam int NUM_LAYERS = 6;
    localparam int NUM_JOINTS = 3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [MODE_W-1:0] MODE_CONTROL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 3'd7;

    localparam logic [LAYER_W-1:0] LAYER_LAST_VALID = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_STALE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LAYER = 2'd2;
    localparam logic [ERR_W-1:0] ERR_MODE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 1'b1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd100;

    typedef struct packed {
        logic [GAIN_W-1:0]  pulse_gain;
        logic [LIMIT_W-1:0] max_pulse_change;
    } gain_cfg_t;

    typedef struct packed {
        logic                      done;
        logic signed [PULSE_W-1:0] pulse;
    } pulse_rsp_t;

endpackage

### sv/sbjpd_ifs.sv
`timescale 1ns / 1ps

interface sbjpd_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [sbjpd_pkg::STAMP_W-1:0]      spike_time;
    logic [sbjpd_pkg::LAYER_W-1:0]      spike_layer;
    logic [sbjpd_pkg::STAMP_W-1:0]      current_time;
    logic [sbjpd_pkg::MODE_W-1:0]       mode;

    modport source (output valid, operation, spike_time, spike_layer, current_time, mode,
                    input ready);
    modport sink (input valid, operation, spike_time, spike_layer, current_time, mode,
                  output ready);
endinterface

interface sbjpd_out_if;
    logic                               valid;
    logic                               ready;
    logic [sbjpd_pkg::ERR_W-1:0]        error_code;
    logic                               pulses_valid;
    logic signed [sbjpd_pkg::PULSE_W-1:0] base_pulse;
    logic signed [sbjpd_pkg::PULSE_W-1:0] shoulder_pulse;
    logic signed [sbjpd_pkg::PULSE_W-1:0] elbow_pulse;
    logic [sbjpd_pkg::DRAIN_W-1:0]      drained_count;
    logic                               overflow_flag;

    modport source (output valid, error_code, pulses_valid, base_pulse, shoulder_pulse,
                    elbow_pulse, drained_count, overflow_flag,
                    input ready);
    modport sink (input valid, error_code, pulses_valid, base_pulse, shoulder_pulse,
                  elbow_pulse, drained_count, overflow_flag,
                  output ready);
endinterface

interface sbjpd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sbjpd_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [sbjpd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, reg_index, data, input ready);
    modport sink (input valid, reg_index, data, output ready);
endinterface

### sv/spike_buffer_to_joint_pulse_drive_top.sv
`timescale 1ns / 1ps
// channel     | modport | carries
// ------------+---------+--------------------------------------------------
// spike_in    | sink    | push (stamp, layer) or tick (current time, mode)
// result_out  | source  | one result per tick: error, pulses, drained count, overflow
// cfg         | sink    | register writes: pulse gain, max pulse change
//
// a tick drains entries through the ring read loop (one entry a cycle through
// the registered memory read), then in control mode runs the three-stage
// pulse unit once per joint.
// no item is taken while a tick is at work; a push is taken while a result
// waits, a tick finishes and then waits for the result register to empty.
// rst_n is asynchronous; the ring memory is not cleared, only its pointers.
`include "spike_buffer_to_joint_pulse_drive_top_assert.svh"

module spike_buffer_to_joint_pulse_drive_top #(
    parameter int BUFFER_DEPTH = sbjpd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sbjpd_in_if.sink     spike_in,
    sbjpd_out_if.source  result_out,
    sbjpd_cfg_if.sink    cfg
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int DWIDE = PTR_W + sbjpd_pkg::DRAIN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DRAIN  = 2'd1;
    localparam logic [1:0] ST_PULSE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
        return q;
    endfunction

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [sbjpd_pkg::ENTRY_W-1:0] ring_mem [BUFFER_DEPTH];
    logic [sbjpd_pkg::ENTRY_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_adv;

    logic [sbjpd_pkg::STAMP_W-1:0] prev_reg;
    logic [sbjpd_pkg::STAMP_W-1:0] now_reg;
    logic                          control_reg;
    logic [sbjpd_pkg::ERR_W-1:0]   err_reg;
    logic [PTR_W-1:0]              drained_reg;
    logic [PTR_W-1:0]              count_reg [sbjpd_pkg::NUM_LAYERS];
    logic                          overflow_reg;
    logic [sbjpd_pkg::GAIN_W-1:0]  gain_reg;
    logic [sbjpd_pkg::LIMIT_W-1:0] limit_reg;
    logic [1:0]                    issue_reg;
    logic [1:0]                    collect_reg;
    logic signed [sbjpd_pkg::PULSE_W-1:0] pulse_reg [sbjpd_pkg::NUM_JOINTS];

    logic                                 out_valid_reg;
    logic [sbjpd_pkg::ERR_W-1:0]          out_err_reg;
    logic                                 out_pv_reg;
    logic signed [sbjpd_pkg::PULSE_W-1:0] out_base_reg;
    logic signed [sbjpd_pkg::PULSE_W-1:0] out_shoulder_reg;
    logic signed [sbjpd_pkg::PULSE_W-1:0] out_elbow_reg;
    logic [sbjpd_pkg::DRAIN_W-1:0]        out_drained_reg;
    logic                                 out_overflow_reg;

    logic [sbjpd_pkg::STAMP_W-1:0] rd_stamp;
    logic [sbjpd_pkg::LAYER_W-1:0] rd_layer;
    logic                          ring_empty;
    logic                          ring_full;
    logic                          in_acc;
    logic                          push_acc;
    logic                          tick_acc;
    logic                          in_drain;
    logic                          stale;
    logic                          fresh;
    logic                          take;
    logic                          bad_layer;
    logic                          drain_stop;
    logic [sbjpd_pkg::ERR_W-1:0]   drain_err;
    logic                          issue_go;
    logic                          finish_load;
    logic [PTR_W-1:0]              req_flex;
    logic [PTR_W-1:0]              req_ext;
    logic [DWIDE-1:0]              drained_wide;
    logic [sbjpd_pkg::PULSE_W-1:0] limit16;
    logic                          pulses_in_range;

    sbjpd_pkg::gain_cfg_t  gain_cfg;
    sbjpd_pkg::pulse_rsp_t pulse_rsp;

    assign rd_stamp   = rd_data_reg[sbjpd_pkg::ENTRY_W-1:sbjpd_pkg::LAYER_W];
    assign rd_layer   = rd_data_reg[sbjpd_pkg::LAYER_W-1:0];
    assign ring_empty = (rp_reg == wp_reg);
    assign wp_adv     = next_slot(wp_reg);
    assign ring_full  = (wp_adv == rp_reg);

    assign spike_in.ready = (state_reg == ST_IDLE);
    assign in_acc   = spike_in.valid && spike_in.ready;
    assign push_acc = in_acc && (spike_in.operation == sbjpd_pkg::OP_PUSH);
    assign tick_acc = in_acc && (spike_in.operation == sbjpd_pkg::OP_TICK);

    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_drain   = (state_reg == ST_DRAIN);
        stale      = rd_stamp < prev_reg;
        fresh      = rd_stamp >= now_reg;
        take       = in_drain && !ring_empty && !stale && !fresh;
        bad_layer  = control_reg && (rd_layer > sbjpd_pkg::LAYER_LAST_VALID);
        drain_stop = in_drain && (ring_empty || stale || fresh || bad_layer);
        if (in_drain && !ring_empty && stale)
            drain_err = sbjpd_pkg::ERR_STALE;
        else if (take && bad_layer)
            drain_err = sbjpd_pkg::ERR_LAYER;
        else
            drain_err = sbjpd_pkg::ERR_OK;
        rp_next = take ? next_slot(rp_reg) : rp_reg;
    end

    // joint j: extensor count 2j, flexor count 2j+1
    always_comb
    begin
        issue_go = (state_reg == ST_PULSE) && (issue_reg != 2'(sbjpd_pkg::NUM_JOINTS));
        case (issue_reg)
            2'd0:
            begin
                req_ext  = count_reg[0];
                req_flex = count_reg[1];
            end
            2'd1:
            begin
                req_ext  = count_reg[2];
                req_flex = count_reg[3];
            end
            default:
            begin
                req_ext  = count_reg[4];
                req_flex = count_reg[5];
            end
        endcase
    end

    assign gain_cfg.pulse_gain       = gain_reg;
    assign gain_cfg.max_pulse_change = limit_reg;

    sbjpd_pulse #(
        .CNT_W (PTR_W)
    ) u_pulse (
        .clk   (clk),
        .rst_n (rst_n),
        .start (issue_go),
        .flex  (req_flex),
        .ext   (req_ext),
        .cfg   (gain_cfg),
        .rsp   (pulse_rsp)
    );

    assign finish_load = (state_reg == ST_FINISH) && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                    state_next = (spike_in.mode == sbjpd_pkg::MODE_INVALID) ? ST_FINISH
                                                                           : ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_stop)
                    state_next = (control_reg && drain_err == sbjpd_pkg::ERR_OK) ? ST_PULSE
                                                                                : ST_FINISH;
            end
            ST_PULSE:
            begin
                if (pulse_rsp.done && collect_reg == 2'(sbjpd_pkg::NUM_JOINTS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_load)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (push_acc && !ring_full)
            ring_mem[wp_reg] <= {spike_in.spike_time, spike_in.spike_layer};
        rd_data_reg <= ring_mem[rp_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rp_reg       <= '0;
            wp_reg       <= '0;
            prev_reg     <= '0;
            overflow_reg <= 1'b0;
            gain_reg     <= sbjpd_pkg::GAIN_RESET;
            limit_reg    <= sbjpd_pkg::LIMIT_RESET;
            issue_reg    <= '0;
            collect_reg  <= '0;
            drained_reg  <= '0;
            for (int i = 0; i < sbjpd_pkg::NUM_LAYERS; i++)
                count_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.reg_index)
                    sbjpd_pkg::REG_PULSE_GAIN: gain_reg  <= cfg.data;
                    sbjpd_pkg::REG_MAX_PULSE:  limit_reg <= cfg.data[sbjpd_pkg::LIMIT_W-1:0];
                endcase
            end

            if (push_acc)
            begin
                if (ring_full)
                    overflow_reg <= 1'b1;
                else
                    wp_reg <= wp_adv;
            end

            if (tick_acc)
            begin
                issue_reg   <= '0;
                collect_reg <= '0;
                drained_reg <= '0;
                for (int i = 0; i < sbjpd_pkg::NUM_LAYERS; i++)
                    count_reg[i] <= '0;
            end

            if (take)
            begin
                drained_reg <= PTR_W'(drained_reg + 1'b1);
                if (control_reg && !bad_layer)
                    count_reg[rd_layer] <= PTR_W'(count_reg[rd_layer] + 1'b1);
            end

            if (drain_stop && drain_err == sbjpd_pkg::ERR_OK)
                prev_reg <= now_reg;

            if (issue_go)
                issue_reg <= 2'(issue_reg + 1'b1);
            if (pulse_rsp.done)
                collect_reg <= 2'(collect_reg + 1'b1);

            if (finish_load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // tick payload and result register
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            now_reg     <= spike_in.current_time;
            control_reg <= (spike_in.mode == sbjpd_pkg::MODE_CONTROL);
            err_reg     <= (spike_in.mode == sbjpd_pkg::MODE_INVALID) ? sbjpd_pkg::ERR_MODE
                                                                     : sbjpd_pkg::ERR_OK;
            for (int j = 0; j < sbjpd_pkg::NUM_JOINTS; j++)
                pulse_reg[j] <= '0;
        end
        if (drain_stop)
            err_reg <= drain_err;
        if (pulse_rsp.done)
        begin
            case (collect_reg)
                2'd0:    pulse_reg[0] <= pulse_rsp.pulse;
                2'd1:    pulse_reg[1] <= pulse_rsp.pulse;
                default: pulse_reg[2] <= pulse_rsp.pulse;
            endcase
        end
        if (finish_load)
        begin
            out_err_reg      <= err_reg;
            out_pv_reg       <= control_reg && (err_reg == sbjpd_pkg::ERR_OK);
            out_base_reg     <= pulse_reg[0];
            out_shoulder_reg <= pulse_reg[1];
            out_elbow_reg    <= pulse_reg[2];
            out_drained_reg  <= drained_wide[sbjpd_pkg::DRAIN_W-1:0];
            out_overflow_reg <= overflow_reg;
        end
    end

    assign drained_wide = DWIDE'(drained_reg);

    assign result_out.valid          = out_valid_reg;
    assign result_out.error_code     = out_err_reg;
    assign result_out.pulses_valid   = out_pv_reg;
    assign result_out.base_pulse     = out_base_reg;
    assign result_out.shoulder_pulse = out_shoulder_reg;
    assign result_out.elbow_pulse    = out_elbow_reg;
    assign result_out.drained_count  = out_drained_reg;
    assign result_out.overflow_flag  = out_overflow_reg;

    assign limit16 = sbjpd_pkg::PULSE_W'(limit_reg);
    assign pulses_in_range =
        ($signed(out_base_reg) <= $signed(limit16)) &&
        ($signed(out_base_reg) >= -$signed(limit16)) &&
        ($signed(out_shoulder_reg) <= $signed(limit16)) &&
        ($signed(out_shoulder_reg) >= -$signed(limit16)) &&
        ($signed(out_elbow_reg) <= $signed(limit16)) &&
        ($signed(out_elbow_reg) >= -$signed(limit16));

    `SBJPD_ASSERT_NOW(a_pulses_only_ok, result_out.valid && out_pv_reg, out_err_reg == sbjpd_pkg::ERR_OK, "pulses flagged valid on an error tick")
    `SBJPD_ASSERT_NOW(a_pulses_zero, result_out.valid && !out_pv_reg, out_base_reg == '0 && out_shoulder_reg == '0 && out_elbow_reg == '0, "nonzero pulse without valid pulses")
    `SBJPD_ASSERT_NOW(a_pulse_clamped, result_out.valid && out_pv_reg, pulses_in_range, "pulse beyond max pulse change")
    `SBJPD_ASSERT_NEXT(a_full_push_flags, push_acc && ring_full, overflow_reg && wp_reg == $past(wp_reg), "push into full ring not dropped")
    `SBJPD_ASSERT_NOW(a_overflow_sticky, 1'b1, !$fell(overflow_reg), "overflow flag cleared")

endmodule

### sv/sbjpd_pulse.sv
`timescale 1ns / 1ps

module sbjpd_pulse #(
    parameter int CNT_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [CNT_W-1:0]       flex,
    input  logic [CNT_W-1:0]       ext,
    input  sbjpd_pkg::gain_cfg_t   cfg,
    output sbjpd_pkg::pulse_rsp_t  rsp
);

    localparam int PROD_W = CNT_W + sbjpd_pkg::GAIN_W;
    localparam int SHR_W  = PROD_W - 8;
    localparam int CMP_W  = (SHR_W > sbjpd_pkg::LIMIT_W) ? SHR_W : sbjpd_pkg::LIMIT_W;

    logic              s1_valid_reg;
    logic              s1_neg_reg;
    logic [CNT_W-1:0]  s1_mag_reg;
    logic              s2_valid_reg;
    logic              s2_neg_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic              done_reg;
    logic signed [sbjpd_pkg::PULSE_W-1:0] pulse_reg;

    logic [CMP_W-1:0]  shifted;
    logic [CMP_W-1:0]  limit_wide;
    logic [CMP_W-1:0]  clamped;
    logic [sbjpd_pkg::PULSE_W-1:0] mag16;

    always_comb
    begin
        shifted    = CMP_W'(s2_prod_reg[PROD_W-1:8]);
        limit_wide = CMP_W'(cfg.max_pulse_change);
        clamped    = (shifted > limit_wide) ? limit_wide : shifted;
        mag16      = sbjpd_pkg::PULSE_W'(clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // magnitude, product, clamp
    always_ff @(posedge clk)
    begin
        s1_neg_reg  <= ext > flex;
        s1_mag_reg  <= (ext > flex) ? (ext - flex) : (flex - ext);
        s2_neg_reg  <= s1_neg_reg;
        s2_prod_reg <= PROD_W'(s1_mag_reg) * PROD_W'(cfg.pulse_gain);
        pulse_reg   <= s2_neg_reg ? $signed(-mag16) : $signed(mag16);
    end

    assign rsp.done  = done_reg;
    assign rsp.pulse = pulse_reg;

endmodule

### test/spike_buffer_to_joint_pulse_drive_top_tb.sv
`timescale 1ns / 1ps

module spike_buffer_to_joint_pulse_drive_top_tb;

    import sbjpd_pkg::*;

    localparam int DEPTH = BUFFER_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 600;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_DRAIN_FIRST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DRAIN_LAST  = 3'd6;

    localparam logic [LAYER_W-1:0] LAYER_BASE_EXT      = 3'd0;
    localparam logic [LAYER_W-1:0] LAYER_BASE_FLEX     = 3'd1;
    localparam logic [LAYER_W-1:0] LAYER_SHOULDER_EXT  = 3'd2;
    localparam logic [LAYER_W-1:0] LAYER_SHOULDER_FLEX = 3'd3;
    localparam logic [LAYER_W-1:0] LAYER_ELBOW_EXT     = 3'd4;
    localparam logic [LAYER_W-1:0] LAYER_ELBOW_FLEX    = 3'd5;
    localparam logic [LAYER_W-1:0] LAYER_BAD_LO        = 3'd6;
    localparam logic [LAYER_W-1:0] LAYER_BAD_HI        = 3'd7;

    typedef struct {
        logic [ERR_W-1:0]          error_code;
        logic                      pulses_valid;
        logic signed [PULSE_W-1:0] base_pulse;
        logic signed [PULSE_W-1:0] shoulder_pulse;
        logic signed [PULSE_W-1:0] elbow_pulse;
        logic [DRAIN_W-1:0]        drained_count;
        logic                      overflow_flag;
    } drive_result_t;

    logic clk;
    logic rst_n;

    sbjpd_in_if  spike_if ();
    sbjpd_out_if result_if ();
    sbjpd_cfg_if cfg_if ();

    spike_buffer_to_joint_pulse_drive_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .spike_in   (spike_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // predicted block state
    logic [STAMP_W-1:0] ring_stamp [DEPTH];
    logic [LAYER_W-1:0] ring_layer [DEPTH];
    int unsigned        rd_ptr = 0;
    int unsigned        wr_ptr = 0;
    logic [STAMP_W-1:0] last_tick_time = '0;
    logic               overflow_seen = 1'b0;
    logic [GAIN_W-1:0]  model_gain = GAIN_RESET;
    logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;

    drive_result_t pending_results [$];

    logic [STAMP_W-1:0] newest_stamp = '0;
    bit in_gaps = 1'b1;
    bit out_gaps = 1'b1;
    bit hold_req = 1'b0;
    logic hold_on;
    int cycle_count = 0;
    int fail_count = 0;
    int push_count = 0;
    int tick_count = 0;
    int checked_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[STAMP_W-1:0];
    endfunction

    function automatic logic signed [PULSE_W-1:0] joint_pulse(input int unsigned flex,
                                                              input int unsigned ext);
        logic [63:0] mag;
        logic        neg;
        neg = ext > flex;
        mag = neg ? 64'(ext - flex) : 64'(flex - ext);
        mag = (mag * 64'(model_gain)) >> 8;
        if (mag > 64'(model_limit))
            mag = 64'(model_limit);
        return neg ? -mag[PULSE_W-1:0] : mag[PULSE_W-1:0];
    endfunction

    function automatic drive_result_t predict_tick(input logic [STAMP_W-1:0] now,
                                                   input logic [MODE_W-1:0] md);
        drive_result_t      res;
        int unsigned        counts [NUM_LAYERS];
        int unsigned        drained;
        logic [ERR_W-1:0]   err;
        logic               ctrl;
        logic [STAMP_W-1:0] st;
        logic [LAYER_W-1:0] ly;
        foreach (counts[k])
            counts[k] = 0;
        drained = 0;
        err = ERR_OK;
        ctrl = (md == MODE_CONTROL);
        if (md == MODE_INVALID)
            err = ERR_MODE;
        else
        begin
            while (rd_ptr != wr_ptr)
            begin
                st = ring_stamp[rd_ptr];
                ly = ring_layer[rd_ptr];
                if (st < last_tick_time)
                begin
                    err = ERR_STALE;
                    break;
                end
                if (st >= now)
                    break;
                rd_ptr = (rd_ptr + 1) % DEPTH;
                drained++;
                if (ctrl)
                begin
                    if (ly > LAYER_LAST_VALID)
                    begin
                        err = ERR_LAYER;
                        break;
                    end
                    counts[ly]++;
                end
            end
        end
        res.error_code = err;
        res.pulses_valid = ctrl && (err == ERR_OK);
        res.base_pulse = '0;
        res.shoulder_pulse = '0;
        res.elbow_pulse = '0;
        if (err == ERR_OK)
        begin
            last_tick_time = now;
            if (ctrl)
            begin
                res.base_pulse = joint_pulse(counts[LAYER_BASE_FLEX], counts[LAYER_BASE_EXT]);
                res.shoulder_pulse = joint_pulse(counts[LAYER_SHOULDER_FLEX],
                                                 counts[LAYER_SHOULDER_EXT]);
                res.elbow_pulse = joint_pulse(counts[LAYER_ELBOW_FLEX],
                                              counts[LAYER_ELBOW_EXT]);
            end
        end
        res.drained_count = DRAIN_W'(drained);
        res.overflow_flag = overflow_seen;
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [STAMP_W-1:0] stime,
                             input logic [LAYER_W-1:0] layer,
                             input logic [STAMP_W-1:0] now, input logic [MODE_W-1:0] md);
        while (in_gaps && $urandom_range(0, 99) < 37)
        begin
            spike_if.valid <= 1'b0;
            @(posedge clk);
        end
        spike_if.valid <= 1'b1;
        spike_if.operation <= op;
        spike_if.spike_time <= stime;
        spike_if.spike_layer <= layer;
        spike_if.current_time <= now;
        spike_if.mode <= md;
        @(posedge clk);
        while (spike_if.ready !== 1'b1)
            @(posedge clk);
        if (op == OP_PUSH)
        begin
            if ((wr_ptr + 1) % DEPTH == rd_ptr)
                overflow_seen = 1'b1;
            else
            begin
                ring_stamp[wr_ptr] = stime;
                ring_layer[wr_ptr] = layer;
                wr_ptr = (wr_ptr + 1) % DEPTH;
            end
            push_count++;
        end
        else
        begin
            pending_results.push_back(predict_tick(now, md));
            tick_count++;
        end
    endtask

    // unused fields of each transaction carry random values
    task automatic push_spike(input logic [STAMP_W-1:0] stamp, input logic [LAYER_W-1:0] layer);
        send_item(OP_PUSH, stamp, layer, rand_stamp(), MODE_W'($urandom_range(0, 7)));
        newest_stamp = stamp;
    endtask

    task automatic tick_at(input logic [STAMP_W-1:0] now, input logic [MODE_W-1:0] md);
        send_item(OP_TICK, rand_stamp(), LAYER_W'($urandom_range(0, 7)), now, md);
    endtask

    task automatic push_next(input logic [LAYER_W-1:0] layer);
        push_spike(newest_stamp + 1'b1, layer);
    endtask

    task automatic tick_next(input logic [MODE_W-1:0] md);
        tick_at(newest_stamp + 1'b1, md);
    endtask

    task automatic settle();
        spike_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] word);
        cfg_if.valid <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.data <= word;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_PULSE_GAIN)
            model_gain = word;
        else
            model_limit = word[LIMIT_W-1:0];
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] gain_word,
                             input logic [CFG_DATA_W-1:0] limit_word);
        settle();
        write_reg(REG_PULSE_GAIN, gain_word);
        write_reg(REG_MAX_PULSE, limit_word);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic test_directed_basics();
        logic [LAYER_W-1:0] layer_seq [9];
        layer_seq = '{LAYER_BASE_EXT, LAYER_BASE_FLEX, LAYER_SHOULDER_EXT, LAYER_SHOULDER_FLEX,
                      LAYER_ELBOW_EXT, LAYER_ELBOW_FLEX, LAYER_BASE_FLEX, LAYER_BASE_FLEX,
                      LAYER_SHOULDER_EXT};
        tick_at('0, MODE_CONTROL);
        foreach (layer_seq[k])
            push_spike(STAMP_W'(k), layer_seq[k]);
        tick_at(100, MODE_INVALID);
        tick_at(3, MODE_CONTROL);
        tick_at(100, MODE_CONTROL);
        // drain-only modes pass bad layers through
        push_spike(200, LAYER_BAD_LO);
        push_spike(201, LAYER_BAD_HI);
        tick_at(300, MODE_DRAIN_FIRST);
        // bad layer in control mode stops the drain
        push_spike(310, LAYER_SHOULDER_EXT);
        push_spike(311, LAYER_BAD_HI);
        push_spike(312, LAYER_BASE_FLEX);
        tick_at(400, MODE_CONTROL);
        tick_at(400, MODE_CONTROL);
        push_spike(STAMP_MAX - 1'b1, LAYER_BASE_FLEX);
        tick_at(STAMP_MAX, MODE_CONTROL);
        tick_at('0, MODE_DRAIN_LAST);
        newest_stamp = last_tick_time;
    endtask

    task automatic test_pulse_scaling();
        configure(16'hFFFF, 16'h7FFF);
        push_next(LAYER_BASE_FLEX);
        push_next(LAYER_SHOULDER_EXT);
        push_next(LAYER_SHOULDER_EXT);
        push_next(LAYER_ELBOW_FLEX);
        tick_next(MODE_CONTROL);
        // gain 1.5: truncation toward zero, then clamp at one
        configure(16'd384, 16'd1);
        push_next(LAYER_BASE_EXT);
        push_next(LAYER_SHOULDER_FLEX);
        tick_next(MODE_CONTROL);
        push_next(LAYER_BASE_EXT);
        push_next(LAYER_BASE_EXT);
        push_next(LAYER_ELBOW_EXT);
        tick_next(MODE_CONTROL);
        configure(16'd0, 16'd0);
        push_next(LAYER_BASE_FLEX);
        push_next(LAYER_ELBOW_EXT);
        tick_next(MODE_CONTROL);
        // top bit of the limit write is dropped
        configure(16'd128, 16'h8064);
        push_next(LAYER_ELBOW_EXT);
        push_next(LAYER_SHOULDER_FLEX);
        push_next(LAYER_SHOULDER_FLEX);
        tick_next(MODE_CONTROL);
    endtask

    task automatic test_random_traffic();
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] now;
        logic [MODE_W-1:0]  md;
        int r;
        int span;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: configure(16'hFFFF, 16'h7FFF);
                1: configure(16'd0, 16'($urandom));
                2: configure(16'($urandom), 16'd0);
                3: configure(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 400)));
                default: configure(16'($urandom), 16'($urandom));
            endcase
            in_gaps = (p != 2);
            out_gaps = (p != 2);
            if (p == 3)
                hold_req = 1'b1;
            for (int i = 0; i < 200; i++)
            begin
                r = $urandom_range(0, 99);
                if (rd_ptr == wr_ptr && r < 4)
                begin
                    // empty ring: move the time base anywhere
                    stamp = rand_stamp();
                    if (&stamp[STAMP_W-1:41])
                        stamp[41] = 1'b0;
                    if ($urandom_range(0, 3) == 0)
                        stamp = STAMP_W'($urandom_range(0, 1000));
                    tick_at(stamp, MODE_W'($urandom_range(MODE_DRAIN_FIRST, MODE_DRAIN_LAST)));
                    newest_stamp = stamp;
                end
                else if (r < 64)
                begin
                    stamp = (newest_stamp > last_tick_time) ? newest_stamp : last_tick_time;
                    stamp = stamp + STAMP_W'($urandom_range(0, 15));
                    if ($urandom_range(0, 99) < 4)
                        push_spike(stamp, LAYER_W'($urandom_range(LAYER_BAD_LO, LAYER_BAD_HI)));
                    else
                        push_spike(stamp,
                                   LAYER_W'($urandom_range(LAYER_BASE_EXT, LAYER_ELBOW_FLEX)));
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                        md = MODE_CONTROL;
                    else if (r < 93)
                    begin
                        md = MODE_W'($urandom_range(MODE_DRAIN_FIRST, MODE_DRAIN_LAST - 1));
                        if (md >= MODE_CONTROL)
                            md++;
                    end
                    else
                        md = MODE_INVALID;
                    if ($urandom_range(0, 99) < 12)
                    begin
                        span = (last_tick_time < 40) ? int'(last_tick_time) : 40;
                        now = last_tick_time - STAMP_W'($urandom_range(0, span));
                    end
                    else
                    begin
                        span = (newest_stamp < 8) ? int'(newest_stamp) : 8;
                        now = newest_stamp - STAMP_W'(span) + STAMP_W'($urandom_range(0, 10));
                    end
                    tick_at(now, md);
                end
            end
        end
        in_gaps = 1'b1;
        out_gaps = 1'b1;
    endtask

    task automatic test_ring_overflow();
        tick_at(STAMP_MAX, MODE_DRAIN_FIRST);
        tick_at(1000, MODE_DRAIN_LAST);
        newest_stamp = 1000;
        in_gaps = 1'b0;
        for (int k = 0; k < DEPTH + 6; k++)
            push_next(LAYER_W'($urandom_range(0, 7)));
        in_gaps = 1'b1;
        tick_at(500, MODE_DRAIN_FIRST);
        tick_at(STAMP_MAX - 1'b1, MODE_DRAIN_FIRST);
    endtask

    // a stale entry blocks the ring for good, so this runs last
    task automatic test_stale_stamp();
        push_spike(5, LAYER_BASE_FLEX);
        tick_at(STAMP_MAX, MODE_CONTROL);
        push_spike(STAMP_MAX, LAYER_SHOULDER_EXT);
        tick_at(10, MODE_INVALID);
        tick_at(10, MODE_DRAIN_FIRST);
    endtask

    initial
    begin : result_checker
        drive_result_t want;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result transaction with none expected, error_code %0d",
                             $time, result_if.error_code);
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_count++;
                    check_field("error_code", want.error_code, result_if.error_code);
                    check_field("pulses_valid", want.pulses_valid, result_if.pulses_valid);
                    check_field("base_pulse", want.base_pulse, result_if.base_pulse);
                    check_field("shoulder_pulse", want.shoulder_pulse,
                                result_if.shoulder_pulse);
                    check_field("elbow_pulse", want.elbow_pulse, result_if.elbow_pulse);
                    check_field("drained_count", want.drained_count, result_if.drained_count);
                    check_field("overflow_flag", want.overflow_flag, result_if.overflow_flag);
                end
            end
            result_if.ready <= !(hold_on || (out_gaps && $urandom_range(0, 99) < 37));
        end
    end

    initial
    begin : result_hold
        hold_on <= 1'b0;
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
            hold_req = 1'b0;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        spike_if.valid <= 1'b0;
        spike_if.operation <= OP_PUSH;
        spike_if.spike_time <= '0;
        spike_if.spike_layer <= '0;
        spike_if.current_time <= '0;
        spike_if.mode <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.reg_index <= REG_PULSE_GAIN;
        cfg_if.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_pulse_scaling();
        test_random_traffic();
        test_ring_overflow();
        test_stale_stamp();
        settle();
        $display("covered %0d pushes and %0d ticks, %0d results checked", push_count,
                 tick_count, checked_count);
        $display("gain and clamp extremes, full ring overflow, stale stamp, bad layer and mode");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
